// ===== rtl/wsfd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the WebSocket frame decoder.
// Depends on nothing; every rtl module uses it by scoped names.
package wsfd_pkg;

    // Parser phases
    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // Result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Short length codes and header byte counts
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] CNT_EXT16 = 4'd2;
    localparam logic [3:0] CNT_EXT64 = 4'd8;
    localparam logic [3:0] CNT_KEY   = 4'd4;

    // Result queue between parser and output stage
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // One queued result request
    typedef struct packed {
        logic        kind;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [7:0]  data;
        logic        last;
        logic [31:0] key;
        logic [1:0]  key_sel;
    } t_entry;

endpackage

// ===== rtl/wsfd_front.sv =====
`timescale 1ns / 1ps
// Header parser: tracks frame phase and turns each accepted byte into
// zero or one queued result request. Depends on wsfd_pkg.
module wsfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [7:0]          i_byte,
    output logic                o_push,
    output wsfd_pkg::t_entry    o_entry
);

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_count, n_count;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_mask, n_mask;
    logic [63:0] r_length, n_length;
    logic [31:0] r_key, n_key;
    logic [63:0] r_remain, n_remain;
    logic [1:0]  r_offs, n_offs;

    logic        len_done;
    logic [63:0] ext_len;
    logic [31:0] ext_key;
    logic        fin;

    assign ext_len = {r_length[55:0], i_byte};
    assign ext_key = {r_key[23:0], i_byte};
    assign fin     = (r_remain == 64'd1);

    // Decode the next phase and the result request
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_opcode = r_opcode;
        n_mask   = r_mask;
        n_length = r_length;
        n_key    = r_key;
        n_remain = r_remain;
        n_offs   = r_offs;
        len_done = 1'b0;
        o_push   = 1'b0;
        o_entry  = '0;
        if (i_acc) begin
            unique case (r_phase)
                wsfd_pkg::PH_LEN: begin
                    n_mask = i_byte[7];
                    if (i_byte[6:0] == wsfd_pkg::LEN_EXT16) begin
                        n_length = '0;
                        n_count  = wsfd_pkg::CNT_EXT16;
                        n_phase  = wsfd_pkg::PH_EXTLEN;
                    end else if (i_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
                        n_length = '0;
                        n_count  = wsfd_pkg::CNT_EXT64;
                        n_phase  = wsfd_pkg::PH_EXTLEN;
                    end else begin
                        n_length = {57'd0, i_byte[6:0]};
                        len_done = 1'b1;
                    end
                end
                wsfd_pkg::PH_EXTLEN: begin
                    n_length = ext_len;
                    n_count  = r_count - 4'd1;
                    len_done = (r_count == 4'd1);
                end
                wsfd_pkg::PH_KEY: begin
                    n_key   = ext_key;
                    n_count = r_count - 4'd1;
                    if (r_count == 4'd1) begin
                        o_push   = 1'b1;
                        n_remain = r_length;
                        n_offs   = '0;
                        n_phase  = (r_length == 64'd0) ? wsfd_pkg::PH_FIRST
                                                       : wsfd_pkg::PH_PAYLOAD;
                    end
                end
                wsfd_pkg::PH_PAYLOAD: begin
                    o_push   = 1'b1;
                    n_remain = r_remain - 64'd1;
                    n_offs   = r_offs + 2'd1;
                    if (fin) begin
                        n_phase = wsfd_pkg::PH_FIRST;
                    end
                end
                default: begin
                    n_opcode = i_byte[3:0];
                    n_phase  = wsfd_pkg::PH_LEN;
                end
            endcase
        end

        // Length known: collect the key or finish the header
        if (len_done) begin
            if (n_mask) begin
                n_count = wsfd_pkg::CNT_KEY;
                n_key   = '0;
                n_phase = wsfd_pkg::PH_KEY;
            end else begin
                o_push   = 1'b1;
                n_remain = n_length;
                n_offs   = '0;
                n_phase  = (n_length == 64'd0) ? wsfd_pkg::PH_FIRST
                                               : wsfd_pkg::PH_PAYLOAD;
            end
        end

        // Build the request from the updated frame fields
        o_entry.opcode  = n_opcode;
        o_entry.masked  = n_mask;
        o_entry.length  = n_length;
        o_entry.key     = n_key;
        o_entry.key_sel = r_offs;
        if (r_phase == wsfd_pkg::PH_PAYLOAD) begin
            o_entry.kind = wsfd_pkg::KIND_PAYLOAD;
            o_entry.data = i_byte;
            o_entry.last = fin;
        end else begin
            o_entry.kind = wsfd_pkg::KIND_HEADER;
            o_entry.data = '0;
            o_entry.last = (n_length == 64'd0);
        end
    end

    // Hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsfd_pkg::PH_FIRST;
            r_count  <= '0;
            r_opcode <= '0;
            r_mask   <= 1'b0;
            r_length <= '0;
            r_key    <= '0;
            r_remain <= '0;
            r_offs   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_opcode <= n_opcode;
            r_mask   <= n_mask;
            r_length <= n_length;
            r_key    <= n_key;
            r_remain <= n_remain;
            r_offs   <= n_offs;
        end
    end

endmodule

// ===== rtl/wsfd_queue.sv =====
`timescale 1ns / 1ps
// Two-entry request queue between the parser and the output stage.
// Depends on wsfd_pkg for the entry type and depth.
module wsfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wsfd_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output wsfd_pkg::t_entry    o_entry
);

    wsfd_pkg::t_entry         r_mem [wsfd_pkg::Q_DEPTH];
    logic [wsfd_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [wsfd_pkg::Q_AW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (wsfd_pkg::Q_AW+1)'(wsfd_pkg::Q_DEPTH));
    assign o_entry = r_mem[r_rp];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/wsfd_back.sv =====
`timescale 1ns / 1ps
// Output stage: unmasks payload bytes with the frame key and holds the
// result in a register until taken. Depends on wsfd_pkg.
module wsfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  wsfd_pkg::t_entry    i_entry,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic                o_kind,
    output logic [3:0]          o_frame_opcode,
    output logic                o_is_masked,
    output logic [63:0]         o_frame_length,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);

    logic        r_valid;
    logic [31:0] r_key;
    logic [7:0]  key_byte;
    logic [7:0]  n_byte;

    assign o_pop   = i_q_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;

    // Pick the key byte for this payload offset
    always_comb begin
        unique case (i_entry.key_sel)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        n_byte = i_entry.data;
        if (i_entry.kind == wsfd_pkg::KIND_PAYLOAD && i_entry.masked) begin
            n_byte = i_entry.data ^ key_byte;
        end
    end

    // Hold output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Load result fields; latch the key at each header
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_kind         <= i_entry.kind;
            o_frame_opcode <= i_entry.opcode;
            o_is_masked    <= i_entry.masked;
            o_frame_length <= i_entry.length;
            o_out_byte     <= n_byte;
            o_last         <= i_entry.last;
            if (i_entry.kind == wsfd_pkg::KIND_HEADER) begin
                r_key <= i_entry.key;
            end
        end
    end

endmodule

// ===== rtl/websocket_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// WebSocket frame decoder top level: parser, request queue, output stage.
// Each result is written into the request queue and then registered in the output stage.
// Throughput: 1 byte per cycle while o_stall is low, set by the parser phase register.
// The 2-entry queue stalls input only when the output side is held.
// Reset: synchronous, active low; clears phase, queue and output valid.
module websocket_frame_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [3:0]  o_frame_opcode,
    output logic        o_is_masked,
    output logic [63:0] o_frame_length,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    logic             w_acc;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_q_valid;
    wsfd_pkg::t_entry w_push_entry;
    wsfd_pkg::t_entry w_head_entry;

    assign o_stall = w_full;
    assign w_acc   = i_valid && !w_full;

    wsfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_byte  (i_in_byte),
        .o_push  (w_push),
        .o_entry (w_push_entry)
    );

    wsfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_full),
        .o_entry (w_head_entry)
    );

    wsfd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_entry        (w_head_entry),
        .o_pop          (w_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_frame_opcode (o_frame_opcode),
        .o_is_masked    (o_is_masked),
        .o_frame_length (o_frame_length),
        .o_out_byte     (o_out_byte),
        .o_last         (o_last)
    );

    // Queue never takes a request when full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("request pushed into full queue");

    // Header results carry a zero byte
    a_header_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wsfd_pkg::KIND_HEADER) |-> (o_out_byte == 8'd0))
        else $error("header result with non-zero byte");

    // A header ends the frame exactly when the length is zero
    a_header_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wsfd_pkg::KIND_HEADER) |->
            (o_last == (o_frame_length == 64'd0)))
        else $error("header last flag disagrees with length");

    // Payload bytes only belong to non-empty frames
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wsfd_pkg::KIND_PAYLOAD) |->
            (o_frame_length != 64'd0))
        else $error("payload byte in zero-length frame");

endmodule
